// File: src/esdp_pkg.sv
// es descriptor parser package: item types, config bundle, verdict codes
// no dependencies; imported by every module of the parser
`default_nettype none

package esdp_pkg;

  localparam int unsigned MaxSizeBytes = 4;
  localparam int unsigned LenW         = 28;
  localparam int unsigned AddrW        = 5;
  localparam int unsigned DataW        = 32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } es_in_t;

  typedef struct packed {
    logic            payload_valid;
    logic [7:0]      payload_byte;
    logic [2:0]      verdict;
    logic [7:0]      obj_type_code;
    logic            is_aac;
    logic [LenW-1:0] payload_length;
  } es_out_t;

  typedef struct packed {
    logic [7:0] es_tag;
    logic [7:0] config_tag;
    logic [7:0] info_tag;
    logic [7:0] aac_type_first;
    logic [7:0] aac_type_second;
  } esdp_cfg_t;

  typedef enum logic [2:0] {
    VerdictPending  = 3'd0,
    VerdictOk       = 3'd1,
    VerdictBadOuter = 3'd2,
    VerdictUrl      = 3'd3,
    VerdictBadCfg   = 3'd4,
    VerdictBadInfo  = 3'd5,
    VerdictTrunc    = 3'd6
  } verdict_e;

  typedef enum logic [2:0] {
    RegEsTag     = 3'd0,
    RegCfgTag    = 3'd1,
    RegInfoTag   = 3'd2,
    RegAacFirst  = 3'd3,
    RegAacSecond = 3'd4
  } reg_idx_e;

endpackage

`default_nettype wire

// File: src/es_descriptor_parser.sv
// es descriptor parser top level: one descriptor byte per item in, one result item out
// the result item is registered in the result register behind the input register; throughput: 1 item per cycle
// while out_stall_i does not hold the result; the phase update between the two registers is combinational
// reset: async active low; parse state returns to the outer tag phase, registers to defaults
// depends on esdp_pkg, esdp_regs, esdp_core
`default_nettype none

module es_descriptor_parser
  import esdp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire es_in_t           in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output es_out_t               out_data_o
);

  esdp_cfg_t cfg;

  esdp_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  esdp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // input backpressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_payload_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_data_o.payload_valid) |-> (out_data_o.payload_byte == 8'd0))
    else $error("payload byte set without payload valid");

  a_aac_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.is_aac) |->
      (out_data_o.obj_type_code == cfg.aac_type_first ||
       out_data_o.obj_type_code == cfg.aac_type_second))
    else $error("aac flag without matching object type");

  a_verdict_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.verdict <= VerdictTrunc))
    else $error("verdict code out of range");

endmodule

`default_nettype wire

// File: src/esdp_regs.sv
// apb configuration registers of the es descriptor parser
// depends on esdp_pkg
`default_nettype none

module esdp_regs
  import esdp_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             psel,
  input  wire logic             penable,
  input  wire logic             pwrite,
  input  wire logic [AddrW-1:0] paddr,
  input  wire logic [DataW-1:0] pwdata,
  output logic      [DataW-1:0] prdata,
  output logic                  pready,
  output esdp_cfg_t             cfg_o
);

  esdp_cfg_t  cfg_q;
  logic       wr_en;
  logic [2:0] idx;
  logic [7:0] rd_byte;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = paddr[AddrW-1:2];
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.es_tag          <= 8'd3;
      cfg_q.config_tag      <= 8'd4;
      cfg_q.info_tag        <= 8'd5;
      cfg_q.aac_type_first  <= 8'd64;
      cfg_q.aac_type_second <= 8'd103;
    end else if (wr_en) begin
      unique case (idx)
        RegEsTag:     cfg_q.es_tag          <= pwdata[7:0];
        RegCfgTag:    cfg_q.config_tag      <= pwdata[7:0];
        RegInfoTag:   cfg_q.info_tag        <= pwdata[7:0];
        RegAacFirst:  cfg_q.aac_type_first  <= pwdata[7:0];
        RegAacSecond: cfg_q.aac_type_second <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      RegEsTag:     rd_byte = cfg_q.es_tag;
      RegCfgTag:    rd_byte = cfg_q.config_tag;
      RegInfoTag:   rd_byte = cfg_q.info_tag;
      RegAacFirst:  rd_byte = cfg_q.aac_type_first;
      RegAacSecond: rd_byte = cfg_q.aac_type_second;
      default:      rd_byte = 8'd0;
    endcase
  end

  assign prdata = {{(DataW-8){1'b0}}, rd_byte};

endmodule

`default_nettype wire

// File: src/esdp_core.sv
// parse engine: input register, phase machine and result register
// depends on esdp_pkg
`default_nettype none

module esdp_core
  import esdp_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire esdp_cfg_t cfg_i,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire es_in_t    in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output es_out_t        out_data_o
);

  localparam logic [3:0] PhOuterTag  = 4'd0;
  localparam logic [3:0] PhOuterSize = 4'd1;
  localparam logic [3:0] PhEsid      = 4'd2;
  localparam logic [3:0] PhFlags     = 4'd3;
  localparam logic [3:0] PhOptSkip   = 4'd4;
  localparam logic [3:0] PhCfgTag    = 4'd5;
  localparam logic [3:0] PhCfgSize   = 4'd6;
  localparam logic [3:0] PhObjType   = 4'd7;
  localparam logic [3:0] PhCfgSkip   = 4'd8;
  localparam logic [3:0] PhInfoTag   = 4'd9;
  localparam logic [3:0] PhInfoSize  = 4'd10;
  localparam logic [3:0] PhPayload   = 4'd11;
  localparam logic [3:0] PhDone      = 4'd12;
  localparam logic [3:0] PhError     = 4'd13;

  // input stage
  logic   in_valid_q;
  es_in_t in_q;
  logic   out_free;
  logic   adv;

  // parse state
  logic [3:0]      phase_q, phase_d;
  logic [LenW-1:0] acc_q, acc_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [3:0]      skip_q, skip_d;
  logic [LenW-1:0] rem_q, rem_d;
  logic [7:0]      obj_q, obj_d;
  logic [2:0]      err_q, err_d;
  logic            done_q, done_d;
  logic            seen_q, seen_d;
  logic [LenW-1:0] decl_q, decl_d;

  // result stage
  logic    out_valid_q;
  es_out_t out_q;
  es_out_t res;

  logic [7:0]      b;
  logic [2:0]      cnt_inc;
  logic [LenW-1:0] acc_sh;
  logic            size_end;
  logic            skip_end;
  logic [3:0]      skip_dec;
  logic [LenW-1:0] rem_dec;
  logic [1:0]      nopt;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign adv        = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= (in_valid_i && !in_stall_o) || (in_valid_q && !adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  assign b        = in_q.data_byte;
  assign cnt_inc  = {1'b0, cnt_q} + 3'd1;
  assign acc_sh   = {acc_q[LenW-8:0], b[6:0]};
  assign size_end = !b[7] || (cnt_inc >= 3'(MaxSizeBytes));
  assign skip_end = skip_q <= 4'd1;
  assign skip_dec = skip_q - 4'd1;
  assign rem_dec  = rem_q - {{(LenW-1){1'b0}}, 1'b1};
  assign nopt     = {1'b0, b[7]} + {1'b0, b[5]};

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    cnt_d   = cnt_q;
    skip_d  = skip_q;
    rem_d   = rem_q;
    obj_d   = obj_q;
    err_d   = err_q;
    done_d  = done_q;
    seen_d  = seen_q;
    decl_d  = decl_q;
    res     = '0;

    unique case (phase_q)
      PhOuterTag, PhCfgTag, PhInfoTag: begin
        if (phase_q == PhOuterTag && b != cfg_i.es_tag) begin
          err_d   = VerdictBadOuter;
          phase_d = PhError;
        end else if (phase_q == PhCfgTag && b != cfg_i.config_tag) begin
          err_d   = VerdictBadCfg;
          phase_d = PhError;
        end else if (phase_q == PhInfoTag && b != cfg_i.info_tag) begin
          err_d   = VerdictBadInfo;
          phase_d = PhError;
        end else begin
          acc_d   = '0;
          cnt_d   = '0;
          phase_d = phase_q + 4'd1;
        end
      end
      PhOuterSize, PhCfgSize, PhInfoSize: begin
        acc_d = acc_sh;
        if (size_end) begin
          cnt_d = '0;
          if (phase_q == PhOuterSize) begin
            skip_d  = 4'd2;
            phase_d = PhEsid;
          end else if (phase_q == PhCfgSize) begin
            phase_d = PhObjType;
          end else begin
            decl_d = acc_sh;
            rem_d  = acc_sh;
            if (acc_sh == '0) begin
              done_d  = 1'b1;
              phase_d = PhDone;
            end else begin
              phase_d = PhPayload;
            end
          end
        end else begin
          cnt_d = cnt_inc[1:0];
        end
      end
      PhEsid, PhOptSkip, PhCfgSkip: begin
        if (skip_end) begin
          skip_d  = '0;
          phase_d = (phase_q == PhEsid)    ? PhFlags :
                    (phase_q == PhOptSkip) ? PhCfgTag : PhInfoTag;
        end else begin
          skip_d = skip_dec;
        end
      end
      PhFlags: begin
        if (b[6]) begin
          err_d   = VerdictUrl;
          phase_d = PhError;
        end else begin
          skip_d  = {1'b0, nopt, 1'b0};
          phase_d = (nopt == 2'd0) ? PhCfgTag : PhOptSkip;
        end
      end
      PhObjType: begin
        obj_d   = b;
        seen_d  = 1'b1;
        skip_d  = 4'd12;
        phase_d = PhCfgSkip;
      end
      PhPayload: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = b;
        rem_d             = rem_dec;
        if (rem_dec == '0) begin
          done_d  = 1'b1;
          phase_d = PhDone;
        end
      end
      default: ;
    endcase

    res.obj_type_code  = obj_d;
    res.is_aac         = seen_d && (obj_d == cfg_i.aac_type_first ||
                                    obj_d == cfg_i.aac_type_second);
    res.payload_length = decl_d;

    if (in_q.last_byte) begin
      if (err_d != VerdictPending) begin
        res.verdict = err_d;
      end else if (done_d) begin
        res.verdict = VerdictOk;
      end else begin
        res.verdict = VerdictTrunc;
      end
      phase_d = PhOuterTag;
      acc_d   = '0;
      cnt_d   = '0;
      skip_d  = '0;
      rem_d   = '0;
      obj_d   = '0;
      err_d   = VerdictPending;
      done_d  = 1'b0;
      seen_d  = 1'b0;
      decl_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhOuterTag;
      acc_q   <= '0;
      cnt_q   <= '0;
      skip_q  <= '0;
      rem_q   <= '0;
      obj_q   <= '0;
      err_q   <= VerdictPending;
      done_q  <= 1'b0;
      seen_q  <= 1'b0;
      decl_q  <= '0;
    end else if (adv) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      skip_q  <= skip_d;
      rem_q   <= rem_d;
      obj_q   <= obj_d;
      err_q   <= err_d;
      done_q  <= done_d;
      seen_q  <= seen_d;
      decl_q  <= decl_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// self-checking testbench for es_descriptor_parser: byte items in, one result item per byte out
// an in-bench parser model predicts every result; apb port sweeps the tag and aac registers
// depends on esdp_pkg and es_descriptor_parser
`default_nettype none

module tb_top;
  import esdp_pkg::*;

  localparam int NumRegs = 5;
  localparam int MaxGap = 8;
  localparam int LongHold = 300;
  localparam int SettleCycles = 4;
  localparam int WatchdogLimit = 2000;
  localparam int ItemsPerSetting = 300;
  localparam logic [AddrW-1:0] UnusedRegAddr = AddrW'(20);

  typedef enum logic [3:0] {
    PhOuterTag, PhOuterSize, PhStreamId, PhFlags, PhOptSkip, PhCfgTag, PhCfgSize,
    PhObjType, PhCfgSkip, PhInfoTag, PhInfoSize, PhPayload, PhDone, PhError
  } parse_phase_e;

  typedef enum int {
    SetDefault, SetAllZero, SetAllOnes, SetRandom, SetRandomAgain, SetCount
  } reg_setting_e;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  es_in_t           in_data_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  es_out_t          out_data_o;

  es_descriptor_parser uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial forever #4 clk_i = ~clk_i;

  // parser model state
  logic [7:0]   reg_mirror [NumRegs];
  parse_phase_e parse_phase;
  logic [27:0]  size_acc;
  int unsigned  size_cnt;
  int unsigned  skip_left;
  logic [27:0]  payload_left;
  logic [7:0]   obj_type;
  logic         type_seen;
  logic [27:0]  declared_len;
  verdict_e     parse_error;
  logic         parse_done;

  es_out_t    pending_parse_results [$];
  logic [7:0] descriptor_bytes [$];
  int         mismatches = 0;
  int         items_sent = 0;
  int         burst_left = 0;
  bit         sender_gaps = 1'b1;
  logic       hold_req = 1'b0;

  function automatic void clear_parse();
    parse_phase = PhOuterTag;
    size_acc = '0;
    size_cnt = 0;
    skip_left = 0;
    payload_left = '0;
    obj_type = '0;
    type_seen = 1'b0;
    declared_len = '0;
    parse_error = VerdictPending;
    parse_done = 1'b0;
  endfunction

  function automatic void enter_error(input verdict_e code);
    parse_error = code;
    parse_phase = PhError;
  endfunction

  function automatic void mark_done();
    parse_done = 1'b1;
    parse_phase = PhDone;
  endfunction

  function automatic logic size_complete(input logic [7:0] b);
    size_acc = {size_acc[20:0], b[6:0]};
    if (!b[7] || size_cnt + 1 >= MaxSizeBytes) begin
      size_cnt = 0;
      return 1'b1;
    end
    size_cnt = size_cnt + 1;
    return 1'b0;
  endfunction

  function automatic void count_down(input parse_phase_e next_phase);
    if (skip_left <= 1) begin
      skip_left = 0;
      parse_phase = next_phase;
    end else begin
      skip_left = skip_left - 1;
    end
  endfunction

  function automatic void start_size();
    size_acc = '0;
    size_cnt = 0;
  endfunction

  function automatic void advance_parser(input logic [7:0] b, input logic is_last);
    es_out_t res;
    res = '0;
    case (parse_phase)
      PhOuterTag: begin
        if (b != reg_mirror[RegEsTag]) enter_error(VerdictBadOuter);
        else begin
          start_size();
          parse_phase = PhOuterSize;
        end
      end
      PhOuterSize: begin
        if (size_complete(b)) begin
          skip_left = 2;
          parse_phase = PhStreamId;
        end
      end
      PhStreamId: count_down(PhFlags);
      PhFlags: begin
        if (b[6]) enter_error(VerdictUrl);
        else begin
          skip_left = (b[7] ? 2 : 0) + (b[5] ? 2 : 0);
          parse_phase = (skip_left == 0) ? PhCfgTag : PhOptSkip;
        end
      end
      PhOptSkip: count_down(PhCfgTag);
      PhCfgTag: begin
        if (b != reg_mirror[RegCfgTag]) enter_error(VerdictBadCfg);
        else begin
          start_size();
          parse_phase = PhCfgSize;
        end
      end
      PhCfgSize: if (size_complete(b)) parse_phase = PhObjType;
      PhObjType: begin
        obj_type = b;
        type_seen = 1'b1;
        skip_left = 12;
        parse_phase = PhCfgSkip;
      end
      PhCfgSkip: count_down(PhInfoTag);
      PhInfoTag: begin
        if (b != reg_mirror[RegInfoTag]) enter_error(VerdictBadInfo);
        else begin
          start_size();
          parse_phase = PhInfoSize;
        end
      end
      PhInfoSize: begin
        if (size_complete(b)) begin
          declared_len = size_acc;
          payload_left = size_acc;
          if (payload_left == 0) mark_done();
          else parse_phase = PhPayload;
        end
      end
      PhPayload: begin
        res.payload_valid = 1'b1;
        res.payload_byte = b;
        payload_left = payload_left - 28'd1;
        if (payload_left == 0) mark_done();
      end
      default: ;
    endcase
    res.obj_type_code = obj_type;
    res.is_aac = type_seen &&
                 (obj_type == reg_mirror[RegAacFirst] || obj_type == reg_mirror[RegAacSecond]);
    res.payload_length = declared_len;
    res.verdict = VerdictPending;
    if (is_last) begin
      if (parse_error != VerdictPending) res.verdict = parse_error;
      else if (parse_done) res.verdict = VerdictOk;
      else res.verdict = VerdictTrunc;
      clear_parse();
    end
    pending_parse_results.push_back(res);
  endfunction

  // receiver stall pattern, with a long hold-off on request
  int   stall_mode = 0;
  int   mode_cycles = 0;
  int   stall_period = 2;
  int   stall_ctr = 0;
  int   hold_left = 0;
  logic hold_ack = 1'b0;

  always @(posedge clk_i) begin
    if (mode_cycles == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_cycles = $urandom_range(50, 400);
      stall_period = $urandom_range(2, 9);
    end
    mode_cycles = mode_cycles - 1;
    stall_ctr = stall_ctr + 1;
    if (hold_req != hold_ack) begin
      hold_ack = hold_req;
      hold_left = LongHold;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      case (stall_mode)
        0: out_stall_i <= 1'b0;
        1: out_stall_i <= ($urandom_range(0, 3) == 0);
        2: out_stall_i <= ($urandom_range(0, 9) < 6);
        default: out_stall_i <= ((stall_ctr % stall_period) == 0);
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    es_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_parse_results.size() == 0) begin
        $error("result item arrived with nothing pending");
        mismatches++;
      end else begin
        want = pending_parse_results.pop_front();
        if (out_data_o.payload_valid !== want.payload_valid) begin
          $error("payload_valid: expected %0d, got %0d", want.payload_valid,
                 out_data_o.payload_valid);
          mismatches++;
        end
        if (out_data_o.payload_byte !== want.payload_byte) begin
          $error("payload_byte: expected %0h, got %0h", want.payload_byte,
                 out_data_o.payload_byte);
          mismatches++;
        end
        if (out_data_o.verdict !== want.verdict) begin
          $error("verdict: expected %0d, got %0d", want.verdict, out_data_o.verdict);
          mismatches++;
        end
        if (out_data_o.obj_type_code !== want.obj_type_code) begin
          $error("obj_type_code: expected %0h, got %0h", want.obj_type_code,
                 out_data_o.obj_type_code);
          mismatches++;
        end
        if (out_data_o.is_aac !== want.is_aac) begin
          $error("is_aac: expected %0d, got %0d", want.is_aac, out_data_o.is_aac);
          mismatches++;
        end
        if (out_data_o.payload_length !== want.payload_length) begin
          $error("payload_length: expected %0h, got %0h", want.payload_length,
                 out_data_o.payload_length);
          mismatches++;
        end
      end
    end
  end

  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(posedge clk_i);
    end while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic cfg_write(input reg_idx_e idx, input logic [7:0] value);
    reg_mirror[idx] = value;
    apb_write({idx, 2'b00}, {24'($urandom), value});
  endtask

  task automatic cfg_check_all();
    reg_idx_e idx;
    for (int i = 0; i < NumRegs; i++) begin
      idx = reg_idx_e'(i);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= {idx, 2'b00};
      @(posedge clk_i);
      penable <= 1'b1;
      do begin
        @(posedge clk_i);
      end while (!pready);
      if (prdata[7:0] !== reg_mirror[idx]) begin
        $error("%s: expected %0h, got %0h", idx.name(), reg_mirror[idx], prdata[7:0]);
        mismatches++;
      end
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic send_es_byte(input logic [7:0] b, input logic is_last);
    es_in_t item;
    if (sender_gaps && burst_left <= 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, MaxGap)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    item.data_byte = b;
    item.last_byte = is_last;
    in_valid_i <= 1'b1;
    in_data_i <= item;
    do begin
      @(posedge clk_i);
    end while (in_stall_o);
    advance_parser(b, is_last);
    burst_left = burst_left - 1;
    items_sent = items_sent + 1;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    while (pending_parse_results.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic void add_size(input logic [27:0] value);
    int  n;
    bit  overlong;
    logic cont;
    n = 1;
    while (n < MaxSizeBytes && (value >> (7 * n)) != 0) n++;
    if ($urandom_range(0, 3) == 0) n = $urandom_range(n, MaxSizeBytes);
    overlong = ($urandom_range(0, 9) == 0);
    if (overlong) n = MaxSizeBytes;
    for (int i = n - 1; i >= 0; i--) begin
      cont = (i != 0) || overlong;
      descriptor_bytes.push_back({cont, value[7 * i +: 7]});
    end
  endfunction

  function automatic void add_tag(input logic [7:0] tag);
    if ($urandom_range(0, 19) == 0) descriptor_bytes.push_back(tag ^ (8'h01 << $urandom_range(0, 7)));
    else descriptor_bytes.push_back(tag);
  endfunction

  function automatic logic [27:0] random_outer_size();
    if ($urandom_range(0, 9) == 0) return 28'($urandom);
    return 28'($urandom_range(0, 300));
  endfunction

  task automatic send_descriptor(input bit allow_gaps);
    logic [7:0]  flags;
    logic [27:0] pay_len;
    int          n_pay;
    int          cut;
    int          r;
    descriptor_bytes.delete();
    add_tag(reg_mirror[RegEsTag]);
    add_size(random_outer_size());
    descriptor_bytes.push_back(8'($urandom));
    descriptor_bytes.push_back(8'($urandom));
    flags = 8'($urandom);
    flags[6] = ($urandom_range(0, 9) == 0);
    descriptor_bytes.push_back(flags);
    repeat ((flags[7] ? 2 : 0) + (flags[5] ? 2 : 0)) descriptor_bytes.push_back(8'($urandom));
    add_tag(reg_mirror[RegCfgTag]);
    add_size(random_outer_size());
    case ($urandom_range(0, 2))
      0: descriptor_bytes.push_back(reg_mirror[RegAacFirst]);
      1: descriptor_bytes.push_back(reg_mirror[RegAacSecond]);
      default: descriptor_bytes.push_back(8'($urandom));
    endcase
    repeat (12) descriptor_bytes.push_back(8'($urandom));
    add_tag(reg_mirror[RegInfoTag]);
    r = $urandom_range(0, 9);
    if (r < 2) pay_len = '0;
    else if (r < 8) pay_len = 28'($urandom_range(1, 8));
    else if (r == 8) pay_len = 28'($urandom_range(9, 40));
    else pay_len = 28'($urandom) | 28'h80;
    add_size(pay_len);
    n_pay = (pay_len > 40) ? $urandom_range(0, 20) : int'(pay_len);
    repeat (n_pay) descriptor_bytes.push_back(8'($urandom));
    if ($urandom_range(0, 9) < 3) begin
      repeat ($urandom_range(1, 4)) descriptor_bytes.push_back(8'($urandom));
    end
    cut = descriptor_bytes.size();
    if ($urandom_range(0, 9) == 0) cut = $urandom_range(1, cut);
    sender_gaps = allow_gaps && ($urandom_range(0, 3) != 0);
    for (int i = 0; i < cut; i++) send_es_byte(descriptor_bytes[i], i == cut - 1);
  endtask

  task automatic test_register_defaults();
    cfg_check_all();
  endtask

  task automatic test_error_buffers();
    sender_gaps = 1'b1;
    // bad outer tag, then bytes that must be ignored
    send_es_byte(~reg_mirror[RegEsTag], 1'b0);
    send_es_byte(reg_mirror[RegEsTag], 1'b0);
    send_es_byte(8'hFF, 1'b1);
    // lone tag ends truncated
    send_es_byte(reg_mirror[RegEsTag], 1'b1);
    // url flag set
    send_es_byte(reg_mirror[RegEsTag], 1'b0);
    send_es_byte(8'h00, 1'b0);
    send_es_byte(8'h00, 1'b0);
    send_es_byte(8'hFF, 1'b0);
    send_es_byte(8'h40, 1'b1);
    // two-byte size, both optional ids, then a wrong config tag
    send_es_byte(reg_mirror[RegEsTag], 1'b0);
    send_es_byte(8'h81, 1'b0);
    send_es_byte(8'h7F, 1'b0);
    send_es_byte(8'h12, 1'b0);
    send_es_byte(8'h34, 1'b0);
    send_es_byte(8'hA0, 1'b0);
    send_es_byte(8'h00, 1'b0);
    send_es_byte(8'hFF, 1'b0);
    send_es_byte(8'h55, 1'b0);
    send_es_byte(8'hAA, 1'b0);
    send_es_byte(~reg_mirror[RegCfgTag], 1'b1);
    wait_for_results();
  endtask

  task automatic test_well_formed();
    reg_setting_e setting;
    int           first_item;
    for (int s = 0; s < SetCount; s++) begin
      setting = reg_setting_e'(s);
      wait_for_results();
      if (setting != SetDefault) begin
        for (int i = 0; i < NumRegs; i++) begin
          case (setting)
            SetAllZero: cfg_write(reg_idx_e'(i), 8'h00);
            SetAllOnes: cfg_write(reg_idx_e'(i), 8'hFF);
            default: cfg_write(reg_idx_e'(i), 8'($urandom));
          endcase
        end
      end
      if (setting == SetRandom) apb_write(UnusedRegAddr, '1);
      cfg_check_all();
      first_item = items_sent;
      while (items_sent - first_item < ItemsPerSetting) send_descriptor(1'b1);
    end
    wait_for_results();
  endtask

  task automatic test_backpressure();
    int first_item;
    hold_req <= ~hold_req;
    first_item = items_sent;
    while (items_sent - first_item < 200) send_descriptor(1'b0);
    wait_for_results();
  endtask

  task automatic test_noise();
    sender_gaps = 1'b1;
    for (int i = 0; i < 300; i++) begin
      send_es_byte(8'($urandom), (i == 299) || ($urandom_range(0, 15) == 0));
    end
    wait_for_results();
  endtask

  initial begin
    reg_mirror[RegEsTag] = 8'd3;
    reg_mirror[RegCfgTag] = 8'd4;
    reg_mirror[RegInfoTag] = 8'd5;
    reg_mirror[RegAacFirst] = 8'd64;
    reg_mirror[RegAacSecond] = 8'd103;
    clear_parse();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_register_defaults();
    test_error_buffers();
    test_well_formed();
    test_backpressure();
    test_noise();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
